// ===== design/xmcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM checksum sender package
// Shared phase codes, event codes and protocol byte values.
// ----------------------------------------------------------------------------
package xmcs_pkg;

    typedef enum logic [2:0] {
        PH_WAIT   = 3'd0,
        PH_FILL   = 3'd1,
        PH_SEND   = 3'd2,
        PH_ACK    = 3'd3,
        PH_EOT    = 3'd4,
        PH_EOTACK = 3'd5,
        PH_DONE   = 3'd6,
        PH_ABORT  = 3'd7
    } t_phase;

    typedef enum logic [1:0] {
        FN_FILE  = 2'd0,
        FN_RX    = 2'd1,
        FN_EOF   = 2'd2,
        FN_READY = 2'd3
    } t_func;

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] NAK_BYTE = 8'h15;
    localparam logic [7:0] ACK_BYTE = 8'h06;
    localparam logic [7:0] EOT_BYTE = 8'h04;
    localparam logic [7:0] CAN_BYTE = 8'h18;
    localparam logic [7:0] RX_MASK  = 8'h7f;

    localparam logic REG_RETRY   = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;

    // Decoded event handed from the front to the back part.
    typedef struct packed {
        t_func      func;
        logic [7:0] data;
        logic       tick;
        logic       is_nak;
        logic       is_ack;
        logic       is_can;
    } t_event;

    // One result word.
    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       frame_end;
        t_phase     phase;
        logic [7:0] block_number;
    } t_result;

endpackage

// ===== design/xmcs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM sender front end
// Accepts input words, classifies received bytes and queues decoded events.
// ----------------------------------------------------------------------------
module xmcs_front
    import xmcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_data_byte,
    input  logic       i_time_tick,
    output logic       o_ev_valid,
    input  logic       i_ev_ready,
    output t_event     o_ev
);

    // Two-entry event queue.
    t_event     r_q [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;
    logic [7:0] w_rx;
    t_event     w_ev;

    // Classify the incoming word.
    always_comb begin
        w_rx        = i_data_byte & RX_MASK;
        w_ev.func   = t_func'(i_func);
        w_ev.data   = i_data_byte;
        w_ev.tick   = i_time_tick;
        w_ev.is_nak = (w_rx == NAK_BYTE);
        w_ev.is_ack = (w_rx == ACK_BYTE);
        w_ev.is_can = (w_rx == CAN_BYTE);
    end

    assign o_ready    = (r_cnt != 2'd2);
    assign o_ev_valid = (r_cnt != 2'd0);
    assign o_ev       = r_q[r_rp];
    assign w_push     = i_valid && o_ready;
    assign w_pop      = o_ev_valid && i_ev_ready;

    // Pointer and count update.
    always_comb begin
        n_wp  = w_push ? ~r_wp : r_wp;
        n_rp  = w_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_ev;
        end
    end

endmodule

// ===== design/xmcs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM sender back end
// Runs the protocol state machine, holds the block buffer and registers
// one result word per event.
// ----------------------------------------------------------------------------
module xmcs_back
    import xmcs_pkg::*;
#(
    parameter int BLOCK_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_retry_limit,
    input  logic [15:0] i_timeout_limit,
    input  logic        i_ev_valid,
    output logic        o_ev_ready,
    input  t_event      i_ev,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output t_result     o_res
);

    localparam int IW = $clog2(BLOCK_BYTES);
    localparam int CW = $clog2(BLOCK_BYTES + 1);
    localparam int SW = $clog2(BLOCK_BYTES + 4);
    localparam logic [SW-1:0] LAST_IDX = SW'(BLOCK_BYTES + 3);

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_fill, n_fill;
    logic [SW-1:0] r_sidx, n_sidx;
    logic [7:0]    r_seq, n_seq, r_sum, n_sum, r_retry, n_retry;
    logic [15:0]   r_timer, n_timer;
    logic          r_eof, n_eof;
    logic [7:0]    r_mem [BLOCK_BYTES];
    logic [7:0]    r_rd;
    logic          r_rd_ok, n_rd_ok;
    logic [IW-1:0] w_rd_addr;
    logic          w_mem_we, w_fire, w_stall;
    logic          w_txv, w_fend;
    logic [7:0]    w_txb;
    logic          r_res_valid;
    t_result       r_res;

    // Output register; the buffer read is pre-fetched one index ahead, so
    // each ready tick needs the next entry. A result held stalls the back.
    assign w_stall     = r_res_valid && !i_res_ready;
    assign o_ev_ready  = !w_stall;
    assign w_fire      = i_ev_valid && o_ev_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // Next state and result for one event.
    always_comb begin
        logic timed;
        logic [15:0] tinc;
        logic [SW-1:0] d;
        n_phase  = r_phase;
        n_fill   = r_fill;
        n_sidx   = r_sidx;
        n_seq    = r_seq;
        n_sum    = r_sum;
        n_retry  = r_retry;
        n_timer  = r_timer;
        n_eof    = r_eof;
        w_txv    = 1'b0;
        w_txb    = 8'd0;
        w_fend   = 1'b0;
        w_mem_we = 1'b0;
        timed    = 1'b0;
        d        = r_sidx - SW'(3);
        tinc     = (r_timer != 16'hffff) ? r_timer + 16'd1 : r_timer;
        if (i_ev.tick && (r_phase == PH_WAIT || r_phase == PH_ACK ||
                          r_phase == PH_EOT || r_phase == PH_EOTACK)) begin
            n_timer = tinc;
            if (tinc >= i_timeout_limit) begin
                n_phase = PH_ABORT;
                timed   = 1'b1;
            end
        end
        if (!timed) begin
            if (i_ev.func == FN_EOF && (r_phase == PH_FILL || r_phase == PH_SEND ||
                                        r_phase == PH_ACK)) begin
                n_eof = 1'b1;
            end
            case (r_phase)
                PH_WAIT: begin
                    if (i_ev.func == FN_RX && i_ev.is_nak) begin
                        n_phase = PH_FILL;
                        n_timer = 16'd0;
                    end
                end
                PH_FILL: begin
                    if (i_ev.func == FN_FILE) begin
                        w_mem_we = 1'b1;
                        n_sum    = r_sum + i_ev.data;
                        n_fill   = r_fill + CW'(1);
                        if (r_fill == CW'(BLOCK_BYTES - 1)) begin
                            n_phase = PH_SEND;
                            n_sidx  = '0;
                        end
                    end else if (i_ev.func == FN_EOF) begin
                        n_sidx = '0;
                        if (r_fill == '0) begin
                            n_phase = PH_EOT;
                            n_timer = 16'd0;
                        end else begin
                            n_phase = PH_SEND;
                        end
                    end
                end
                PH_SEND: begin
                    if (i_ev.func == FN_READY) begin
                        w_txv = 1'b1;
                        if (r_sidx == '0) begin
                            w_txb = SOH_BYTE;
                        end else if (r_sidx == SW'(1)) begin
                            w_txb = r_seq;
                        end else if (r_sidx == SW'(2)) begin
                            w_txb = 8'd255 - r_seq;
                        end else if (r_sidx == LAST_IDX) begin
                            w_txb = r_sum;
                        end else begin
                            w_txb = (CW'(d) < r_fill && r_rd_ok) ? r_rd : 8'd0;
                        end
                        if (r_sidx == LAST_IDX) begin
                            w_fend  = 1'b1;
                            n_phase = PH_ACK;
                            n_timer = 16'd0;
                            n_sidx  = '0;
                        end else begin
                            n_sidx = r_sidx + SW'(1);
                        end
                    end
                end
                PH_ACK: begin
                    if (i_ev.func == FN_RX) begin
                        if (i_ev.is_ack) begin
                            n_seq   = r_seq + 8'd1;
                            n_retry = 8'd0;
                            n_fill  = '0;
                            n_sum   = 8'd0;
                            n_sidx  = '0;
                            if (r_eof) begin
                                n_phase = PH_EOT;
                                n_timer = 16'd0;
                            end else begin
                                n_phase = PH_FILL;
                            end
                        end else if (i_ev.is_can) begin
                            n_phase = PH_ABORT;
                        end else if (r_retry >= i_retry_limit) begin
                            w_txv   = 1'b1;
                            w_txb   = CAN_BYTE;
                            w_fend  = 1'b1;
                            n_phase = PH_ABORT;
                        end else begin
                            n_retry = r_retry + 8'd1;
                            n_sidx  = '0;
                            n_phase = PH_SEND;
                        end
                    end
                end
                PH_EOT: begin
                    if (i_ev.func == FN_READY) begin
                        w_txv   = 1'b1;
                        w_txb   = EOT_BYTE;
                        w_fend  = 1'b1;
                        n_phase = PH_EOTACK;
                    end
                end
                PH_EOTACK: begin
                    if (i_ev.func == FN_RX) begin
                        n_phase = i_ev.is_ack ? PH_DONE : PH_EOT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Pre-fetch address: data position of the next send index.
    always_comb begin
        logic [SW-1:0] nd;
        nd        = n_sidx - SW'(3);
        w_rd_addr = IW'(nd);
        n_rd_ok   = (n_sidx >= SW'(3)) && (n_sidx < LAST_IDX);
    end

    // Block buffer: one write port, registered read.
    always_ff @(posedge i_clk) begin
        if (w_fire && w_mem_we) begin
            r_mem[IW'(r_fill)] <= i_ev.data;
        end
        if (w_fire) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_fill      <= '0;
            r_sidx      <= '0;
            r_seq       <= 8'd1;
            r_sum       <= 8'd0;
            r_retry     <= 8'd0;
            r_timer     <= 16'd0;
            r_eof       <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase <= n_phase;
                r_fill  <= n_fill;
                r_sidx  <= n_sidx;
                r_seq   <= n_seq;
                r_sum   <= n_sum;
                r_retry <= n_retry;
                r_timer <= n_timer;
                r_eof   <= n_eof;
                r_rd_ok <= n_rd_ok;
            end
            if (!w_stall) begin
                r_res_valid <= w_fire;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res.tx_valid     <= w_txv;
            r_res.tx_byte      <= w_txb;
            r_res.frame_end    <= w_fend;
            r_res.phase        <= n_phase;
            r_res.block_number <= n_seq;
        end
    end

endmodule

// ===== design/xmodem_checksum_transmitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XMODEM checksum sender
// Builds 128-byte checksum frames from file bytes and drives the send,
// retry, EOT and abort protocol, one result word per input word.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// input     in         i_valid / o_ready      i_func, i_data_byte, i_time_tick
// result    out        o_valid / i_ready      o_tx_valid .. o_block_number
// config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the output is not stalled; a word is
// registered first in the front queue and then in the output register.
// The block buffer is read one send index ahead, so its registered read
// port sets no extra latency. Reset is synchronous; the buffer is not
// cleared. An output stall backs up into the two-entry queue.
// ----------------------------------------------------------------------------
module xmodem_checksum_transmitter
    import xmcs_pkg::*;
#(
    parameter int BLOCK_BYTES = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_data_byte,
    input  logic        i_time_tick,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_tx_valid,
    output logic [7:0]  o_tx_byte,
    output logic        o_frame_end,
    output logic [2:0]  o_phase,
    output logic [7:0]  o_block_number
);

    logic [7:0]  r_retry_limit;
    logic [15:0] r_timeout_limit;
    logic        w_ev_valid, w_ev_ready;
    t_event      w_ev;
    t_result     w_res;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit   <= 8'd10;
            r_timeout_limit <= 16'd60;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_RETRY) begin
                r_retry_limit <= i_cfg_data[7:0];
            end else begin
                r_timeout_limit <= i_cfg_data;
            end
        end
    end

    xmcs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_data_byte (i_data_byte),
        .i_time_tick (i_time_tick),
        .o_ev_valid  (w_ev_valid),
        .i_ev_ready  (w_ev_ready),
        .o_ev        (w_ev)
    );

    xmcs_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_retry_limit   (r_retry_limit),
        .i_timeout_limit (r_timeout_limit),
        .i_ev_valid      (w_ev_valid),
        .o_ev_ready      (w_ev_ready),
        .i_ev            (w_ev),
        .o_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .o_res           (w_res)
    );

    assign o_tx_valid     = w_res.tx_valid;
    assign o_tx_byte      = w_res.tx_byte;
    assign o_frame_end    = w_res.frame_end;
    assign o_phase        = w_res.phase;
    assign o_block_number = w_res.block_number;

    // A frame end is only ever flagged on a sent byte.
    a_fend_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_tx_valid)
        else $error("frame end without a sent byte");

    // A lone CAN control byte is only sent when the block aborts; a checksum
    // of the same value leaves the block waiting for its reply.
    a_can_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tx_valid && o_frame_end && o_tx_byte == CAN_BYTE
        && o_phase != PH_ACK |-> o_phase == PH_ABORT)
        else $error("CAN sent without abort");

    // An EOT byte leaves the block waiting for its acknowledgement.
    a_eot_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tx_valid && o_frame_end && o_tx_byte == EOT_BYTE
        && o_phase != PH_ACK |-> o_phase == PH_EOTACK)
        else $error("EOT sent outside the EOT phase");

endmodule
